// ===== design/sbsd_pkg.sv =====
// Shared types and constants for the servo bus status deframer.
package sbsd_pkg;

  localparam int MAX_DEVICES_DEF = 8;
  localparam int MAX_FRAME_DEF   = 64;

  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 64;
  localparam int DEV_IDX_W   = 3;

  localparam logic [CFG_INDEX_W-1:0] CFG_DEVICE_COUNT = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_DEVICE_IDS   = 1'b1;

  localparam logic [7:0] HDR_FIRST  = 8'hFF;
  localparam logic [7:0] HDR_SECOND = 8'hF5;

  localparam logic [1:0] CODE_STORED   = 2'd0;
  localparam logic [1:0] CODE_MISMATCH = 2'd1;
  localparam logic [1:0] CODE_UNKNOWN  = 2'd2;
  localparam logic [1:0] CODE_BAD_LEN  = 2'd3;

  typedef struct packed {
    logic ld_id;
    logic ld_len;
    logic ld_status;
    logic ld_payload;
    logic finish;
    logic emit_bad_len;
  } ctrl_cmd_t;

  typedef struct packed {
    logic hdr_first;
    logic hdr_second;
    logic len_bad;
    logic len_is_two;
    logic payload_last;
  } dp_status_t;

endpackage

// ===== design/sbsd_ctrl.sv =====
// Frame parsing state machine and result handshake control.
module sbsd_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                rx_valid,
  output logic                rx_ready,
  output logic                frame_valid,
  input  logic                frame_ready,
  input  sbsd_pkg::dp_status_t st,
  output sbsd_pkg::ctrl_cmd_t  cmd
);
  import sbsd_pkg::*;

  typedef enum logic [2:0] {
    HUNT1, HUNT2, ID, LEN, STATUS, PAYLOAD, CHECK
  } phase_t;

  phase_t state, state_next;
  logic   acc;
  logic   emit;

  assign rx_ready = !frame_valid || frame_ready;
  assign acc      = rx_valid && rx_ready;

  always_comb begin
    cmd        = '0;
    state_next = state;
    if (acc) begin
      unique case (state)
        HUNT1: begin
          if (st.hdr_first) state_next = HUNT2;
        end
        HUNT2: begin
          if (st.hdr_second) state_next = ID;
          else if (!st.hdr_first) state_next = HUNT1;
        end
        ID: begin
          cmd.ld_id  = 1'b1;
          state_next = LEN;
        end
        LEN: begin
          if (st.len_bad) begin
            cmd.emit_bad_len = 1'b1;
            state_next       = HUNT1;
          end else begin
            cmd.ld_len = 1'b1;
            state_next = STATUS;
          end
        end
        STATUS: begin
          cmd.ld_status = 1'b1;
          state_next    = st.len_is_two ? CHECK : PAYLOAD;
        end
        PAYLOAD: begin
          cmd.ld_payload = 1'b1;
          if (st.payload_last) state_next = CHECK;
        end
        CHECK: begin
          cmd.finish = 1'b1;
          state_next = HUNT1;
        end
        default: state_next = HUNT1;
      endcase
    end
  end

  assign emit = cmd.emit_bad_len || cmd.finish;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= HUNT1;
      frame_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (emit) frame_valid <= 1'b1;
      else if (frame_ready) frame_valid <= 1'b0;
    end
  end

`ifndef SYNTHESIS
  a_stall_only_on_result: assert property (@(posedge clk) disable iff (rst)
    !rx_ready |-> frame_valid) else $error("input stalled without pending result");
  a_check_gives_result: assert property (@(posedge clk) disable iff (rst)
    (acc && state == CHECK) |=> (frame_valid && state == HUNT1))
    else $error("check byte did not give a result");
  a_bad_len_gives_result: assert property (@(posedge clk) disable iff (rst)
    (acc && state == LEN && st.len_bad) |=> (frame_valid && state == HUNT1))
    else $error("bad length did not give a result");
  a_result_only_at_end: assert property (@(posedge clk) disable iff (rst)
    (!frame_valid && !$past(rst)) |=> (!frame_valid || $past(emit)))
    else $error("result raised without a finished frame");
`endif

endmodule

// ===== design/sbsd_dp.sv =====
// Frame fields, running check sum, device table and result register.
module sbsd_dp #(
  parameter int MAX_DEVICES = sbsd_pkg::MAX_DEVICES_DEF,
  parameter int MAX_FRAME   = sbsd_pkg::MAX_FRAME_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [sbsd_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [sbsd_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic [7:0]                         rx_byte,
  input  sbsd_pkg::ctrl_cmd_t                cmd,
  output sbsd_pkg::dp_status_t               st,
  output logic [1:0]                         frame_code,
  output logic [sbsd_pkg::DEV_IDX_W-1:0]     device_index,
  output logic [7:0]                         device_id,
  output logic [7:0]                         servo_status,
  output logic                               position_updated,
  output logic [15:0]                        servo_position
);
  import sbsd_pkg::*;

  localparam int IDX_W = (MAX_DEVICES > 1) ? $clog2(MAX_DEVICES) : 1;

  logic [3:0]  device_count;
  logic [63:0] device_ids;

  logic [7:0]  frame_id;
  logic [7:0]  frame_length;
  logic [7:0]  frame_status;
  logic [7:0]  payload_remaining;
  logic [7:0]  running_sum;
  logic [15:0] first_payload_bytes;
  logic [7:0]  device_status   [MAX_DEVICES];
  logic [15:0] device_position [MAX_DEVICES];

  logic [9:0]           len_ext;
  logic [7:0]           pl_total;
  logic                 sum_ok;
  logic                 hit;
  logic [DEV_IDX_W-1:0] found;
  logic [IDX_W-1:0]     found_sel;
  logic                 len_four;

  assign len_ext  = {2'b00, rx_byte} + 10'd4;
  assign pl_total = frame_length - 8'd2;
  assign len_four = (frame_length == 8'd4);
  assign sum_ok   = (rx_byte == ~running_sum);

  assign st.hdr_first    = (rx_byte == HDR_FIRST);
  assign st.hdr_second   = (rx_byte == HDR_SECOND);
  assign st.len_bad      = (rx_byte < 8'd2) || (len_ext > 10'(MAX_FRAME));
  assign st.len_is_two   = (frame_length == 8'd2);
  assign st.payload_last = (payload_remaining == 8'd1);

  always_comb begin
    hit   = 1'b0;
    found = '0;
    for (int k = MAX_DEVICES - 1; k >= 0; k--) begin
      if ((4'(k) < device_count) && (device_ids[8*k +: 8] == frame_id)) begin
        hit   = 1'b1;
        found = DEV_IDX_W'(k);
      end
    end
  end

  assign found_sel = found[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      device_count        <= '0;
      device_ids          <= '0;
      frame_id            <= '0;
      frame_length        <= '0;
      frame_status        <= '0;
      payload_remaining   <= '0;
      running_sum         <= '0;
      first_payload_bytes <= '0;
      for (int k = 0; k < MAX_DEVICES; k++) begin
        device_status[k]   <= '0;
        device_position[k] <= '0;
      end
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          CFG_DEVICE_COUNT: device_count <= cfg_data[3:0];
          CFG_DEVICE_IDS:   device_ids   <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.ld_id) begin
        frame_id    <= rx_byte;
        running_sum <= rx_byte;
      end
      if (cmd.emit_bad_len) frame_length <= rx_byte;
      if (cmd.ld_len) begin
        frame_length        <= rx_byte;
        running_sum         <= running_sum + rx_byte;
        first_payload_bytes <= '0;
      end
      if (cmd.ld_status) begin
        frame_status      <= rx_byte;
        running_sum       <= running_sum + rx_byte;
        payload_remaining <= pl_total;
      end
      if (cmd.ld_payload) begin
        if (payload_remaining == pl_total)
          first_payload_bytes[15:8] <= rx_byte;
        else if (payload_remaining == pl_total - 8'd1)
          first_payload_bytes[7:0] <= rx_byte;
        running_sum       <= running_sum + rx_byte;
        payload_remaining <= payload_remaining - 8'd1;
      end
      if (cmd.finish && sum_ok && hit) begin
        device_status[found_sel] <= frame_status;
        if (len_four) device_position[found_sel] <= first_payload_bytes;
      end
    end
  end

  // result register, loaded with the item that ends a frame
  always_ff @(posedge clk) begin
    if (cmd.emit_bad_len) begin
      frame_code       <= CODE_BAD_LEN;
      device_index     <= '0;
      device_id        <= frame_id;
      servo_status     <= '0;
      position_updated <= 1'b0;
      servo_position   <= '0;
    end else if (cmd.finish) begin
      device_id    <= frame_id;
      servo_status <= frame_status;
      if (!sum_ok) begin
        frame_code       <= CODE_MISMATCH;
        device_index     <= '0;
        position_updated <= 1'b0;
        servo_position   <= '0;
      end else if (!hit) begin
        frame_code       <= CODE_UNKNOWN;
        device_index     <= '0;
        position_updated <= 1'b0;
        servo_position   <= '0;
      end else begin
        frame_code       <= CODE_STORED;
        device_index     <= found;
        position_updated <= len_four;
        servo_position   <= len_four ? first_payload_bytes : device_position[found_sel];
      end
    end
  end

endmodule

// ===== design/servo_bus_status_deframer.sv =====
// Servo bus status frame parser: one received byte per item, up to one result per frame.
//
// Takes one received byte per cycle and hunts for the FF F5 header, then parses
// id, length, status, payload and check byte. One result item comes out after the
// check byte of each frame (stored, check mismatch or unknown id), or right after
// a length byte that is below 2 or makes the frame longer than MAX_FRAME. Each byte
// takes one cycle; the input stalls only while a result sits in the output register
// and is not taken, and a result may be taken in the same cycle a new byte enters.
// The id search over the configured devices and the table update happen in the
// check byte's cycle. Write configuration only while the block is idle.
module servo_bus_status_deframer #(
  parameter int MAX_DEVICES = sbsd_pkg::MAX_DEVICES_DEF,
  parameter int MAX_FRAME   = sbsd_pkg::MAX_FRAME_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [sbsd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [sbsd_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             rx_valid,
  output logic                             rx_ready,
  input  logic [7:0]                       rx_byte,
  output logic                             frame_valid,
  input  logic                             frame_ready,
  output logic [1:0]                       frame_code,
  output logic [sbsd_pkg::DEV_IDX_W-1:0]   device_index,
  output logic [7:0]                       device_id,
  output logic [7:0]                       servo_status,
  output logic                             position_updated,
  output logic [15:0]                      servo_position
);
  import sbsd_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t st;

  sbsd_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .rx_valid    (rx_valid),
    .rx_ready    (rx_ready),
    .frame_valid (frame_valid),
    .frame_ready (frame_ready),
    .st          (st),
    .cmd         (cmd)
  );

  sbsd_dp #(
    .MAX_DEVICES (MAX_DEVICES),
    .MAX_FRAME   (MAX_FRAME)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cfg_write        (cfg_write),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .rx_byte          (rx_byte),
    .cmd              (cmd),
    .st               (st),
    .frame_code       (frame_code),
    .device_index     (device_index),
    .device_id        (device_id),
    .servo_status     (servo_status),
    .position_updated (position_updated),
    .servo_position   (servo_position)
  );

endmodule
